>>> src/bpq_pkg.sv
// Package for the bounded pending queue: sizes, payload structs, codes and
// the ring address helper. Used by the top level and the checker; depends on nothing.
package bpq_pkg;

   // Built depth of the queue and width of a stored handle.
   localparam int QUEUE_DEPTH = 64;
   localparam int HANDLE_BITS = 16;

   // Fixed widths of the interface fields.
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 7;
   localparam int LIMIT_W  = 7;

   // Derived widths: ring pointer, and a count that can hold the depth itself.
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   localparam logic [LIMIT_W-1:0] MAX_PENDING_RESET = LIMIT_W'(64);

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD    = 2'd0,
      MODE_TAKE   = 2'd1,
      MODE_REMOVE = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      mode_type                mode;
      logic [HANDLE_BITS-1:0]  task_handle;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [HANDLE_BITS-1:0]  taken_handle;
      logic [LEN_W-1:0]        queue_length;
   } rsp_type;

   // Adds an offset of at most the depth to a ring position and wraps it back
   // into the ring. The sum stays below twice the depth, so one subtract will do.
   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

>>> src/bpq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; width and depth come in as parameters.
module bpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/bounded_pending_queue_with_removal_top.sv
// Top level of the bounded pending queue with removal by handle.
// Depends on bpq_pkg and on the bpq_ram storage instance.

// The block keeps an ordered queue of task handles, oldest first, in a ring
// held in one RAM (QUEUE_DEPTH entries, registered read), with a
// head pointer and a length counter in flip-flops. Each request transfer on
// the req_ channel (add at tail, take oldest, or remove the oldest matching
// handle) yields exactly one response transfer on the rsp_ channel carrying
// a status, the taken handle (zero unless a take succeeded) and the new
// length. Requests are handled one at a time. An add, an unused mode, a take
// from an empty queue and a remove from an empty queue go from the request
// transfer straight to the result register and the done state; a successful
// take first waits in the take state for the RAM read of the head entry.
// A remove walks the queue from the head, one entry per cycle, until it finds
// the handle, then closes the gap by copying each later entry down one place,
// again one per cycle. The pace of a remove is set by the single read port of
// the RAM. The response register stands between the two sides: a new request
// is taken while the previous response is still stalled, and only the
// hand-over of the next finished response waits for it. The RAM needs no
// clearing pass after reset, since no entry is read before it has been
// written. The limit max_pending is written through the csr_ channel while
// the block is idle; an add into an empty queue is always accepted, and the
// length never exceeds QUEUE_DEPTH whatever the limit says.
module bounded_pending_queue_with_removal_top
   import bpq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAKE,
      ST_SEARCH,
      ST_SHIFT,
      ST_DONE
   } state_type;

   // Control state.
   state_type            state_ff,       state_in;
   logic [PTR_W-1:0]     head_ff,        head_in;
   logic [CNT_W-1:0]     count_ff,       count_in;
   logic [LIMIT_W-1:0]   max_pending_ff, max_pending_in;
   logic [CNT_W-1:0]     idx_ff,         idx_in;
   logic                 pend_ff,        pend_in;
   logic                 rsp_valid_ff,   rsp_valid_in;

   // Payload registers.
   logic [CNT_W-1:0]       pend_idx_ff, pend_idx_in;
   logic [HANDLE_BITS-1:0] handle_ff,   handle_in;
   rsp_type                res_ff,      res_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   // RAM port signals.
   logic                   ram_wr_en;
   logic [PTR_W-1:0]       ram_wr_addr;
   logic [HANDLE_BITS-1:0] ram_wr_data;
   logic [PTR_W-1:0]       ram_rd_addr;
   logic [HANDLE_BITS-1:0] ram_rd_data;

   logic req_fire;
   logic queue_full;
   logic rsp_free;

   bpq_ram #(
      .WIDTH (HANDLE_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // The queue is full at the programmed limit or at the built depth,
   // whichever comes first.
   assign queue_full = (CMP_W'(count_ff) >= CMP_W'(max_pending_ff)) ||
                       (count_ff >= CNT_W'(QUEUE_DEPTH));

   // The read port always looks at the entry idx_ff places behind the head.
   // In idle idx_ff is zero, so a take finds the head entry waiting for it
   // in the RAM read register as the block enters the take state.
   assign ram_rd_addr = ring_add(head_ff, idx_ff);

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      max_pending_in = max_pending_ff;
      idx_in         = idx_ff;
      pend_in        = 1'b0;
      pend_idx_in    = pend_idx_ff;
      handle_in      = handle_ff;
      res_in         = res_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = ring_add(head_ff, count_ff);
      ram_wr_data    = req_data.task_handle;

      if (csr_valid && csr_ready) begin
         max_pending_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_fire) begin
               handle_in           = req_data.task_handle;
               res_in.status       = STATUS_OK;
               res_in.taken_handle = '0;
               res_in.queue_length = LEN_W'(count_ff);
               state_in            = ST_DONE;
               case (req_data.mode)
                  MODE_ADD: begin
                     if (count_ff == '0 || !queue_full) begin
                        // An empty queue takes the handle whatever the limit.
                        ram_wr_en           = 1'b1;
                        count_in            = count_ff + CNT_W'(1);
                        res_in.queue_length = LEN_W'(count_ff + CNT_W'(1));
                     end else begin
                        res_in.status = STATUS_FULL;
                     end
                  end
                  MODE_TAKE: begin
                     if (count_ff == '0) begin
                        res_in.status = STATUS_EMPTY;
                     end else begin
                        state_in = ST_TAKE;
                     end
                  end
                  MODE_REMOVE: begin
                     if (count_ff == '0) begin
                        res_in.status = STATUS_NOT_FOUND;
                     end else begin
                        state_in = ST_SEARCH;
                     end
                  end
                  default: begin
                     // The unused mode changes nothing and reports success.
                     res_in.status = STATUS_OK;
                  end
               endcase
            end
         end

         ST_TAKE: begin
            res_in.status       = STATUS_OK;
            res_in.taken_handle = ram_rd_data;
            res_in.queue_length = LEN_W'(count_ff - CNT_W'(1));
            head_in             = ring_add(head_ff, CNT_W'(1));
            count_in            = count_ff - CNT_W'(1);
            state_in            = ST_DONE;
         end

         ST_SEARCH: begin
            // One read is issued per cycle; its data is compared in the next cycle.
            if (idx_ff < count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
               idx_in      = idx_ff + CNT_W'(1);
            end
            if (pend_ff && ram_rd_data == handle_ff) begin
               // Found: the read just issued is dropped, and the copy-down
               // starts at the entry after the match.
               pend_in  = 1'b0;
               idx_in   = pend_idx_ff + CNT_W'(1);
               state_in = ST_SHIFT;
            end else if (!pend_ff && idx_ff >= count_ff) begin
               res_in.status       = STATUS_NOT_FOUND;
               res_in.taken_handle = '0;
               res_in.queue_length = LEN_W'(count_ff);
               state_in            = ST_DONE;
            end
         end

         ST_SHIFT: begin
            // Each entry read last cycle is written one place nearer the head.
            // The write always lands two places below the read issued in the
            // same cycle, and reads only move upwards, so no entry is read
            // after it has been overwritten here.
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = ring_add(head_ff, pend_idx_ff - CNT_W'(1));
               ram_wr_data = ram_rd_data;
            end
            if (idx_ff < count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
               idx_in      = idx_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               res_in.status       = STATUS_OK;
               res_in.taken_handle = '0;
               res_in.queue_length = LEN_W'(count_ff - CNT_W'(1));
               count_in            = count_ff - CNT_W'(1);
               state_in            = ST_DONE;
            end
         end

         ST_DONE: begin
            idx_in = '0;
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         count_ff       <= '0;
         max_pending_ff <= MAX_PENDING_RESET;
         idx_ff         <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         max_pending_ff <= max_pending_in;
         idx_ff         <= idx_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      pend_idx_ff <= pend_idx_in;
      handle_ff   <= handle_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> src/bpq_checker.sv
// Port-level checks for the bounded pending queue, and the bind that attaches
// them to the top level. Depends on bpq_pkg.
module bpq_checker
   import bpq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled response stays offered and unchanged.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("stalled response transfer changed or vanished");

   // The reported length never exceeds the built depth.
   property p_len_bound;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> rsp_data.queue_length <= LEN_W'(QUEUE_DEPTH);
   endproperty
   a_len_bound: assert property (p_len_bound)
      else $error("queue length above built depth");

   // Only a successful request may carry a taken handle.
   property p_taken_zero;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.taken_handle == '0;
   endproperty
   a_taken_zero: assert property (p_taken_zero)
      else $error("taken handle set on a failed request");

   // An empty report means a zero length; a rejected add means a non-empty queue.
   property p_empty_len;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_data.status == STATUS_EMPTY |-> rsp_data.queue_length == '0;
   endproperty
   a_empty_len: assert property (p_empty_len)
      else $error("empty status with non-zero length");

   property p_full_len;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_data.status == STATUS_FULL |-> rsp_data.queue_length != '0;
   endproperty
   a_full_len: assert property (p_full_len)
      else $error("add rejected while the queue was empty");

endmodule

bind bounded_pending_queue_with_removal_top bpq_checker u_bpq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
